// File: src/masked_byte_pattern_search_defines.svh
// assertion helpers shared by the masked byte pattern search rtl
`ifndef MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MBPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mbps_pkg.sv
package mbps_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 64;
    localparam int unsigned WORD_BYTES = 8;
    localparam int unsigned NUM_WORDS  = 4;
    localparam int unsigned CARE_W     = 32;
    localparam int unsigned LEN_W      = 6;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_WORD0 = 3'd0,
        REG_PATTERN_WORD1 = 3'd1,
        REG_PATTERN_WORD2 = 3'd2,
        REG_PATTERN_WORD3 = 3'd3,
        REG_CARE_MASK     = 3'd4,
        REG_PATTERN_LEN   = 3'd5
    } cfg_index_t;

    // per-transfer control broadcast to every cell
    typedef struct packed {
        logic advance;
        logic flush;
    } cell_ctrl_t;

endpackage

// File: src/mbps_stream_if.sv
interface mbps_byte_if;
    logic                            valid;
    logic                            ready;
    logic [mbps_pkg::BYTE_W-1:0]     data_byte;
    logic                            last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_match_if;
    logic                            valid;
    logic                            ready;
    logic [mbps_pkg::COUNT_W-1:0]    match_offset;

    modport source (output valid, output match_offset, input ready);
    modport sink   (input valid, input match_offset, output ready);
endinterface

// File: src/mbps_cell.sv
module mbps_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mbps_pkg::cell_ctrl_t        ctrl,
    input  logic [mbps_pkg::BYTE_W-1:0] data_in,
    input  logic [mbps_pkg::BYTE_W-1:0] pattern_byte,
    input  logic                        care,
    output logic [mbps_pkg::BYTE_W-1:0] data_out,
    output logic                        match_now
);

    logic [mbps_pkg::BYTE_W-1:0] byte_reg;
    logic [mbps_pkg::BYTE_W-1:0] byte_next;

    // window byte at this position agrees with its lined-up pattern byte
    assign match_now = ~care | (data_in == pattern_byte);
    assign byte_next = ctrl.flush ? '0 : data_in;
    assign data_out  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

// File: src/masked_byte_pattern_search.sv
// Masked byte pattern search. Streams one byte per cycle on byte_stream and
// reports, on match_stream, the region offset of the first byte of every
// occurrence of the configured pattern (overlaps included). Each result is
// registered in the result register, so it is ready in the cycle after
// the byte that completes it. Input is taken every cycle while the output
// register is empty or being drained, so the sustained rate is one byte per
// clock, set by the single row of compare cells. Pattern bytes whose care bit
// is clear are wildcards. last_byte closes the region: that byte may still
// complete a match, then the offset counter and the byte window clear.
// Regions shorter than the pattern report nothing. Configuration writes are
// expected only while no transfer is in flight.
`include "masked_byte_pattern_search_defines.svh"

module masked_byte_pattern_search #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbps_pkg::WORD_W-1:0]          cfg_data,
    mbps_byte_if.sink                            byte_stream,
    mbps_match_if.source                         match_stream
);

    localparam logic [mbps_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    // configuration registers
    logic [mbps_pkg::NUM_WORDS-1:0][mbps_pkg::WORD_W-1:0] pattern_reg;
    logic [mbps_pkg::CARE_W-1:0]                          care_reg;
    logic [mbps_pkg::LEN_W-1:0]                           length_reg;

    // region tracking and output stage
    logic [mbps_pkg::COUNT_W-1:0] seen_reg;
    logic [mbps_pkg::COUNT_W-1:0] seen_next;
    logic                         out_valid_reg;
    logic [mbps_pkg::COUNT_W-1:0] offset_reg;
    logic [mbps_pkg::COUNT_W-1:0] offset_next;

    logic                         accept;
    logic [mbps_pkg::LEN_W-1:0]   len_eff;
    logic [mbps_pkg::LEN_W-1:0]   shift_amt;
    logic                         long_enough;
    logic                         hit;
    mbps_pkg::cell_ctrl_t         ctrl;

    // pattern and care bits in window order, newest byte at position 0
    logic [MAX_PATTERN*mbps_pkg::BYTE_W-1:0] pat_rev;
    logic [MAX_PATTERN*mbps_pkg::BYTE_W-1:0] pat_aligned;
    logic [MAX_PATTERN-1:0]                  care_rev;
    logic [MAX_PATTERN-1:0]                  care_aligned;

    // byte window: window[k] feeds cell k, window[0] is the incoming byte
    logic [MAX_PATTERN:0][mbps_pkg::BYTE_W-1:0] window;
    logic [MAX_PATTERN-1:0]                     match_now;

    // configuration decode, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            care_reg    <= '1;
            length_reg  <= mbps_pkg::LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbps_pkg::REG_PATTERN_WORD0: pattern_reg[0] <= cfg_data;
                mbps_pkg::REG_PATTERN_WORD1: pattern_reg[1] <= cfg_data;
                mbps_pkg::REG_PATTERN_WORD2: pattern_reg[2] <= cfg_data;
                mbps_pkg::REG_PATTERN_WORD3: pattern_reg[3] <= cfg_data;
                mbps_pkg::REG_CARE_MASK:     care_reg   <= cfg_data[mbps_pkg::CARE_W-1:0];
                mbps_pkg::REG_PATTERN_LEN:   length_reg <= cfg_data[mbps_pkg::LEN_W-1:0];
                default:                     ;
            endcase
        end
    end

    // a zero length acts as one, anything past the cell count as the cell count
    always_comb
    begin
        if (length_reg == '0)
            len_eff = mbps_pkg::LEN_W'(1);
        else if (length_reg > mbps_pkg::LEN_W'(MAX_PATTERN))
            len_eff = mbps_pkg::LEN_W'(MAX_PATTERN);
        else
            len_eff = length_reg;
    end

    // reverse the pattern so its last byte sits with the newest window byte,
    // then slide by the unused length; positions past the length become wildcards
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_rev
        assign pat_rev[(MAX_PATTERN - 1 - k) * mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W] =
            pattern_reg[k / mbps_pkg::WORD_BYTES]
                       [(k % mbps_pkg::WORD_BYTES) * mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W];
        assign care_rev[MAX_PATTERN - 1 - k] = care_reg[k];
    end

    assign shift_amt    = mbps_pkg::LEN_W'(MAX_PATTERN) - len_eff;
    assign pat_aligned  = pat_rev >> {shift_amt, 3'b000};
    assign care_aligned = care_rev >> shift_amt;

    // output register frees up when empty or drained this cycle
    assign byte_stream.ready = ~out_valid_reg | match_stream.ready;
    assign accept            = byte_stream.valid & byte_stream.ready;

    assign ctrl.advance = accept;
    assign ctrl.flush   = byte_stream.last_byte;

    // the cell row: each cell holds one window byte and compares the byte it receives
    assign window[0] = byte_stream.data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        mbps_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .data_in      (window[k]),
            .pattern_byte (pat_aligned[k * mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W]),
            .care         (care_aligned[k]),
            .data_out     (window[k+1]),
            .match_now    (match_now[k])
        );
    end

    // full match when every window position agrees
    assign hit = &match_now;

    // saturating count of bytes in this region, including the current one
    assign seen_next   = (seen_reg == COUNT_MAX) ? seen_reg : seen_reg + 1'b1;
    assign long_enough = seen_next >= mbps_pkg::COUNT_W'(len_eff);
    assign offset_next = seen_next - mbps_pkg::COUNT_W'(len_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (accept)
        begin
            seen_reg <= byte_stream.last_byte ? '0 : seen_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= hit & long_enough;
        end
        else if (match_stream.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            offset_reg <= offset_next;
        end
    end

    assign match_stream.valid        = out_valid_reg;
    assign match_stream.match_offset = offset_reg;

    // region end clears the offset counter
    `MBPS_ASSERT_NEXT(a_last_clears_count, accept && byte_stream.last_byte,
        seen_reg == '0, "offset counter not cleared after region end")
    // count advances by one per transfer until saturation
    `MBPS_ASSERT_NEXT(a_count_step, accept && !byte_stream.last_byte && seen_reg != COUNT_MAX,
        seen_reg == $past(seen_reg) + 1'b1, "offset counter did not advance")
    // a qualified hit shows up as a result with its offset in the next cycle
    `MBPS_ASSERT_NEXT(a_hit_reported, accept && hit && long_enough,
        match_stream.valid && match_stream.match_offset == $past(offset_next),
        "match not presented on the result port")
    // no result for a region shorter than the pattern
    `MBPS_ASSERT_NEXT(a_short_region_silent, accept && !long_enough,
        !match_stream.valid, "result raised before a full pattern length arrived")

endmodule

// File: tb/tb.sv
module tb;

    // pattern depth of the instance under test
    localparam int unsigned MAX_PAT      = 32;
    // register indexes the block does not decode
    localparam logic [mbps_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [mbps_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    // conventional wildcard character in signature text
    localparam logic [mbps_pkg::BYTE_W-1:0] WILDCARD_CHAR = 8'h3F;
    // extra wait after the drain condition, padded for safety
    localparam int unsigned DRAIN_CYCLES = 4;
    // long receiver hold-off used to back the block up
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned MAX_REPORTS  = 100;

    typedef struct packed {
        logic [mbps_pkg::BYTE_W-1:0] data;
        logic                        last;
    } byte_item_t;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // testbench-side drive, all known from time zero
    logic                           cfg_we    = 1'b0;
    logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mbps_pkg::WORD_W-1:0]    cfg_data  = '0;
    logic                           byte_valid = 1'b0;
    logic [mbps_pkg::BYTE_W-1:0]    byte_data  = '0;
    logic                           byte_last  = 1'b0;
    logic                           match_ready = 1'b0;

    mbps_byte_if  byte_bus ();
    mbps_match_if match_bus ();

    assign byte_bus.valid     = byte_valid;
    assign byte_bus.data_byte = byte_data;
    assign byte_bus.last_byte = byte_last;
    assign match_bus.ready    = match_ready;

    masked_byte_pattern_search i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_stream  (byte_bus),
        .match_stream (match_bus)
    );

    // pending byte transfers, filled by the stimulus process
    byte_item_t pending_bytes [$];
    byte_item_t next_byte;
    int unsigned bytes_queued   = 0;
    int unsigned bytes_accepted = 0;
    bit          byte_taken     = 1'b0;

    // region offsets the scanner is expected to report, oldest first
    logic [mbps_pkg::COUNT_W-1:0] offsets_due [$];
    logic [mbps_pkg::COUNT_W-1:0] want_offset;

    // mirror of the configuration registers
    logic [mbps_pkg::WORD_W-1:0]  pat_words [mbps_pkg::NUM_WORDS];
    logic [mbps_pkg::CARE_W-1:0]  care_bits;
    logic [mbps_pkg::LEN_W-1:0]   len_reg;

    // mirror of the scan state, index 0 holds the newest byte
    logic [mbps_pkg::BYTE_W-1:0]  window [MAX_PAT];
    logic [mbps_pkg::COUNT_W-1:0] seen_count;

    // idling control
    bit          steady       = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned send_gap     = 0;

    // run statistics
    int unsigned mismatches      = 0;
    int unsigned matches_checked = 0;
    int unsigned regions         = 0;
    int unsigned setups          = 0;

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s", $time, what);
        mismatches++;
    endtask

    // mostly no gap, some short, a few long; none at all in steady stretches
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [mbps_pkg::WORD_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [mbps_pkg::BYTE_W-1:0] pat_byte(input int unsigned k);
        return pat_words[k / mbps_pkg::WORD_BYTES]
                        [mbps_pkg::BYTE_W * (k % mbps_pkg::WORD_BYTES) +: mbps_pkg::BYTE_W];
    endfunction

    // length 0 behaves as 1, anything past the window depth as the full window
    function automatic int unsigned active_length();
        if (len_reg == 0)
            return 1;
        if (len_reg > MAX_PAT)
            return MAX_PAT;
        return len_reg;
    endfunction

    // shift one byte into the window and queue the offset of any completed match
    function automatic void scan_byte(input logic [mbps_pkg::BYTE_W-1:0] b, input logic last);
        int unsigned n;
        bit hit;
        n = active_length();
        for (int i = MAX_PAT - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = b;
        if (seen_count != '1)
            seen_count++;
        // short region: nothing until a full pattern worth of bytes is in
        if (seen_count >= n)
        begin
            hit = 1'b1;
            for (int j = 0; j < n; j++)
                if (care_bits[j] && pat_byte(j) != window[n - 1 - j])
                    hit = 1'b0;
            if (hit)
                offsets_due.insert(offsets_due.size(),
                                   seen_count - mbps_pkg::COUNT_W'(n));
        end
        // region end: the closing byte was scanned, now start over
        if (last)
        begin
            window     = '{default: '0};
            seen_count = '0;
        end
    endfunction

    // one register write, applied to the mirror as well
    task automatic write_reg(input logic [mbps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbps_pkg::WORD_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            mbps_pkg::REG_PATTERN_WORD0, mbps_pkg::REG_PATTERN_WORD1,
            mbps_pkg::REG_PATTERN_WORD2, mbps_pkg::REG_PATTERN_WORD3:
                pat_words[idx[1:0]] = value;
            mbps_pkg::REG_CARE_MASK:
                care_bits = value[mbps_pkg::CARE_W-1:0];
            mbps_pkg::REG_PATTERN_LEN:
                len_reg = value[mbps_pkg::LEN_W-1:0];
            default:
                ;
        endcase
    endtask

    task automatic load_setup(input logic [mbps_pkg::WORD_W-1:0] w0,
                              input logic [mbps_pkg::WORD_W-1:0] w1,
                              input logic [mbps_pkg::WORD_W-1:0] w2,
                              input logic [mbps_pkg::WORD_W-1:0] w3,
                              input logic [mbps_pkg::CARE_W-1:0] mask,
                              input logic [mbps_pkg::LEN_W-1:0] len);
        write_reg(mbps_pkg::REG_PATTERN_WORD0, w0);
        write_reg(mbps_pkg::REG_PATTERN_WORD1, w1);
        write_reg(mbps_pkg::REG_PATTERN_WORD2, w2);
        write_reg(mbps_pkg::REG_PATTERN_WORD3, w3);
        write_reg(mbps_pkg::REG_CARE_MASK, {32'h0, mask});
        write_reg(mbps_pkg::REG_PATTERN_LEN, {58'h0, len});
        setups++;
    endtask

    task automatic queue_byte(input logic [mbps_pkg::BYTE_W-1:0] b, input logic last);
        byte_item_t item;
        item.data = b;
        item.last = last;
        pending_bytes.insert(pending_bytes.size(), item);
        bytes_queued++;
    endtask

    task automatic queue_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], close && (i == s.len() - 1));
    endtask

    // planted regions lean on pattern bytes and carry whole occurrences,
    // noise regions are plain random bytes
    task automatic queue_random_region(input int unsigned len, input bit planted);
        logic [mbps_pkg::BYTE_W-1:0] region_bytes [];
        int unsigned n;
        int unsigned pos;
        n = active_length();
        region_bytes = new[len];
        for (int i = 0; i < len; i++)
            if (planted && $urandom_range(0, 99) < 60)
                region_bytes[i] = pat_byte($urandom_range(0, n - 1));
            else
                region_bytes[i] = mbps_pkg::BYTE_W'($urandom_range(0, 255));
        if (planted && len >= n)
        begin
            repeat ($urandom_range(1, 3))
            begin
                pos = $urandom_range(0, len - n);
                for (int j = 0; j < n; j++)
                    if (care_bits[j])
                        region_bytes[pos + j] = pat_byte(j);
            end
        end
        for (int i = 0; i < len; i++)
            queue_byte(region_bytes[i], i == len - 1);
    endtask

    task automatic fill_regions(input int unsigned quota);
        int unsigned start;
        int unsigned n;
        int unsigned len;
        int unsigned roll;
        bit planted;
        start = bytes_queued;
        n = active_length();
        @(posedge clk);
        while (bytes_queued - start < quota)
        begin
            roll = $urandom_range(0, 99);
            planted = roll < 75;
            if (roll < 5)
                len = $urandom_range(100, 150);
            else if (roll < 12 && n > 1)
                len = n - 1;    // one byte short of a match
            else if (planted)
                len = $urandom_range(n, n + 30);
            else
                len = $urandom_range(1, 40);
            queue_random_region(len, planted);
            regions++;
        end
    endtask

    // every queued byte transferred and every expected match seen
    task automatic wait_drained();
        do
            @(negedge clk);
        while (bytes_accepted != bytes_queued || offsets_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // byte driver: hold the offer until it transfers, then gap or next byte
    always @(negedge clk)
    begin
        if (rst_n && !(byte_valid && !byte_taken))
        begin
            if (send_gap > 0)
            begin
                byte_valid <= 1'b0;
                send_gap--;
            end
            else if (pending_bytes.size() != 0)
            begin
                next_byte = pending_bytes.pop_front();
                byte_valid <= 1'b1;
                byte_data  <= next_byte.data;
                byte_last  <= next_byte.last;
                send_gap = idle_gap();
            end
            else
                byte_valid <= 1'b0;
        end
        byte_taken = 1'b0;
    end

    // match receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                match_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                match_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                match_ready <= 1'b1;
                stall_left = idle_gap();
            end
        end
    end

    // monitor: check the match transfer first, since a byte transferred in
    // the same cycle can only produce a later result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (match_bus.valid && match_ready)
            begin
                if (offsets_due.size() == 0)
                    report_mismatch($sformatf("match at offset %0d with none expected",
                                              match_bus.match_offset));
                else
                begin
                    want_offset = offsets_due.pop_front();
                    if (match_bus.match_offset !== want_offset)
                        report_mismatch($sformatf("match_offset %0h, expected %0h",
                                                  match_bus.match_offset, want_offset));
                    matches_checked++;
                end
            end
            if (byte_valid && byte_bus.ready)
            begin
                scan_byte(byte_data, byte_last);
                bytes_accepted++;
                byte_taken = 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        // reset values of the registers and the scan state
        pat_words  = '{default: '0};
        care_bits  = '1;
        len_reg    = 6'd1;
        window     = '{default: '0};
        seen_count = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setup: single zero byte, fully cared
        @(posedge clk);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // wildcard in the last position; a two-byte region is too short,
        // then two hits with the wildcard taking both byte extremes
        load_setup({32'h0, WILDCARD_CHAR, 8'h43, 8'h42, 8'h41}, '0, '0, '0,
                   32'hFFFF_FFF7, 6'd4);
        @(posedge clk);
        queue_text("AB", 1'b1);
        queue_text("ABC", 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_text("ABC", 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // overlapping hits, the last completed by the closing byte;
        // writes to undecoded indexes must change nothing
        load_setup(64'h4141, '0, '0, '0, '1, 6'd2);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        @(posedge clk);
        queue_text("AAAA", 1'b1);
        wait_drained();

        for (int p = 0; p < 12; p++)
        begin
            steady = (p == 5 || p == 9);
            case (p)
                0: load_setup(random_word(), random_word(), random_word(), random_word(),
                              '1, 6'd32);
                // every byte matches, so results pile up behind the hold-off
                1: load_setup(random_word(), random_word(), random_word(), random_word(),
                              '0, 6'd1);
                2: load_setup(random_word(), '0, '0, '0, '1, 6'd0);
                3: load_setup(random_word(), random_word(), random_word(), random_word(),
                              $urandom | $urandom, 6'd63);
                4: load_setup(random_word(), random_word(), random_word(), random_word(),
                              '0, 6'd33);
                5: load_setup('1, '1, '1, '1, '1,
                              mbps_pkg::LEN_W'($urandom_range(1, 8)));
                6: load_setup('0, '0, '0, '0, '1, 6'd3);
                default: load_setup(random_word(), random_word(), random_word(),
                                    random_word(), $urandom | $urandom,
                                    mbps_pkg::LEN_W'($urandom_range(1, 32)));
            endcase
            if (p == 1)
            begin
                @(posedge clk);
                hold_request = 1'b1;
            end
            if (p == 6)
            begin
                // sender stops until every result is in, then resumes
                fill_regions(18);
                wait_drained();
                fill_regions(18);
            end
            else
                fill_regions(36);
            wait_drained();
        end

        wait_drained();
        $display("scanned %0d bytes in %0d random regions under %0d pattern setups",
                 bytes_accepted, regions, setups);
        $display("checked %0d match offsets, %0d mismatches", matches_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit, well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d bytes queued, %0d transferred, %0d matches pending",
                 bytes_queued, bytes_accepted, offsets_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
